[hdl/lpc_pkg.sv]
// Package for the line position centroid unit.
// Holds the sensor weights, field widths, register indexes and shared types.
// No dependencies.
package lpc_pkg;

  localparam int unsigned NUM_LANES   = 6;
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned POS_W       = 13;
  localparam int unsigned QUOT_W      = 12;  // |position| <= 2500 < 2**12
  localparam int unsigned WEIGHT_W    = 12;  // weight magnitudes fit in 12 bits
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 12;

  localparam int unsigned ADC_FULL_SCALE_DEFAULT = 4095;
  localparam logic [SAMPLE_W-1:0] THRESH_RESET = 12'd2000;

  // Sensor weights as magnitude and sign, leftmost sensor first.
  localparam int unsigned WEIGHT_MAG [NUM_LANES] = '{2500, 1500, 500, 500, 1500, 2500};
  localparam logic [NUM_LANES-1:0] WEIGHT_NEG = 6'b000111;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LINE_THRESHOLD = 1'b0,
    CFG_LINE_READS_LOW = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [NUM_LANES-1:0] mask;
    logic [COUNT_W-1:0]   count;
  } lpc_status_t;

  // Width of one strength value for a given full-scale level.
  function automatic int unsigned str_width(input int unsigned full_scale);
    int unsigned top_val;
    top_val = (full_scale > 4095) ? full_scale : 4095;
    return $clog2(top_val + 1);
  endfunction

endpackage

[hdl/lpc_in_if.sv]
// Request channel of the line position centroid unit: one frame of six readings.
// Depends on lpc_pkg.
interface lpc_in_if;
  import lpc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_0;
  logic [SAMPLE_W-1:0] sample_1;
  logic [SAMPLE_W-1:0] sample_2;
  logic [SAMPLE_W-1:0] sample_3;
  logic [SAMPLE_W-1:0] sample_4;
  logic [SAMPLE_W-1:0] sample_5;

  modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                  sample_5, input ready);
  modport sink (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                sample_5, output ready);
endinterface

[hdl/lpc_out_if.sv]
// Result channel of the line position centroid unit.
// Depends on lpc_pkg.
interface lpc_out_if;
  import lpc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [NUM_LANES-1:0]      sensor_mask;
  logic [COUNT_W-1:0]        sensor_hits;
  logic signed [POS_W-1:0]   position;
  logic                      position_valid;

  modport source (output valid, sensor_mask, sensor_hits, position, position_valid,
                  input ready);
  modport sink (input valid, sensor_mask, sensor_hits, position, position_valid,
                output ready);
endinterface

[hdl/lpc_lane.sv]
// One sensor lane: threshold compare, strength and weighted product, registered.
// Depends on lpc_pkg.
module lpc_lane #(
  parameter int unsigned AdcFullScale = lpc_pkg::ADC_FULL_SCALE_DEFAULT,
  parameter int unsigned WeightMag    = 500,
  localparam int unsigned StrW        = lpc_pkg::str_width(AdcFullScale),
  localparam int unsigned ProdW       = StrW + lpc_pkg::WEIGHT_W
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [lpc_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic [lpc_pkg::SAMPLE_W-1:0]  threshold_i,
  input  logic                          reads_low_i,
  output logic                          on_line_o,
  output logic [StrW-1:0]               strength_o,
  output logic [ProdW-1:0]              prod_o
);
  import lpc_pkg::*;

  localparam logic [StrW-1:0] FullScale = StrW'(AdcFullScale);

  logic             on_line_d, on_line_q;
  logic [StrW-1:0]  raw_ext;
  logic [StrW-1:0]  strength_d, strength_q;
  logic [ProdW-1:0] prod_d, prod_q;

  assign raw_ext = StrW'(sample_i);

  always_comb begin
    if (reads_low_i) begin
      on_line_d  = (sample_i <= threshold_i);
      // Readings at or above full scale give no strength.
      strength_d = (raw_ext >= FullScale) ? '0 : FullScale - raw_ext;
    end else begin
      on_line_d  = (sample_i >= threshold_i);
      strength_d = raw_ext;
    end
    prod_d = ProdW'(strength_d) * ProdW'(WeightMag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      on_line_q  <= on_line_d;
      strength_q <= strength_d;
      prod_q     <= prod_d;
    end
  end

  assign on_line_o  = on_line_q;
  assign strength_o = strength_q;
  assign prod_o     = prod_q;

endmodule

[hdl/lpc_merge.sv]
// Merging stage: combines the lane results into mask, count, total strength
// and the sign and magnitude of the weighted sum. Two pipeline stages.
// Depends on lpc_pkg.
module lpc_merge #(
  parameter int unsigned AdcFullScale = lpc_pkg::ADC_FULL_SCALE_DEFAULT,
  localparam int unsigned StrW        = lpc_pkg::str_width(AdcFullScale),
  localparam int unsigned ProdW       = StrW + lpc_pkg::WEIGHT_W,
  localparam int unsigned TotW        = StrW + 3,
  localparam int unsigned MagW        = TotW + lpc_pkg::QUOT_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic                  on_line_i  [lpc_pkg::NUM_LANES],
  input  logic [StrW-1:0]       strength_i [lpc_pkg::NUM_LANES],
  input  logic [ProdW-1:0]      prod_i     [lpc_pkg::NUM_LANES],
  output logic                  valid_o,
  input  logic                  ready_i,
  output lpc_pkg::lpc_status_t  status_o,
  output logic                  neg_o,
  output logic                  zero_o,
  output logic [MagW-1:0]       mag_o,
  output logic [TotW-1:0]       total_o
);
  import lpc_pkg::*;

  logic              va_q, vb_q;
  logic              rdy_a, rdy_b;
  lpc_status_t       status_a_d, status_a_q, status_b_q;
  logic [TotW-1:0]   total_a_d, total_a_q, total_b_q;
  logic [MagW-1:0]   psum_d, psum_q, nsum_d, nsum_q;
  logic [MagW-1:0]   mag_d, mag_q;
  logic              neg_d, neg_q, zero_q;

  assign rdy_b   = !vb_q || ready_i;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;

  always_comb begin
    status_a_d = '0;
    total_a_d  = '0;
    psum_d     = '0;
    nsum_d     = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      status_a_d.mask[i] = on_line_i[i];
      status_a_d.count   = status_a_d.count + COUNT_W'(on_line_i[i]);
      total_a_d          = total_a_d + TotW'(strength_i[i]);
      if (WEIGHT_NEG[i]) begin
        nsum_d = nsum_d + MagW'(prod_i[i]);
      end else begin
        psum_d = psum_d + MagW'(prod_i[i]);
      end
    end
  end

  always_comb begin
    neg_d = (nsum_q > psum_q);
    mag_d = neg_d ? nsum_q - psum_q : psum_q - nsum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      status_a_q <= status_a_d;
      total_a_q  <= total_a_d;
      psum_q     <= psum_d;
      nsum_q     <= nsum_d;
    end
    if (rdy_b && va_q) begin
      status_b_q <= status_a_q;
      total_b_q  <= total_a_q;
      zero_q     <= (total_a_q == '0);
      neg_q      <= neg_d;
      mag_q      <= mag_d;
    end
  end

  assign valid_o  = vb_q;
  assign status_o = status_b_q;
  assign neg_o    = neg_q;
  assign zero_o   = zero_q;
  assign mag_o    = mag_q;
  assign total_o  = total_b_q;

endmodule

[hdl/lpc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, followed by the
// output register that applies the sign and the zero-strength case.
// Depends on lpc_pkg.
module lpc_div #(
  parameter int unsigned AdcFullScale = lpc_pkg::ADC_FULL_SCALE_DEFAULT,
  localparam int unsigned StrW        = lpc_pkg::str_width(AdcFullScale),
  localparam int unsigned TotW        = StrW + 3,
  localparam int unsigned MagW        = TotW + lpc_pkg::QUOT_W
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  lpc_pkg::lpc_status_t            status_i,
  input  logic                            neg_i,
  input  logic                            zero_i,
  input  logic [MagW-1:0]                 mag_i,
  input  logic [TotW-1:0]                 total_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output lpc_pkg::lpc_status_t            status_o,
  output logic signed [lpc_pkg::POS_W-1:0] position_o,
  output logic                            position_valid_o
);
  import lpc_pkg::*;

  localparam int unsigned NStg = QUOT_W;

  logic              v_q      [NStg];
  logic              rdy      [NStg+1];
  logic [MagW-1:0]   rem_q    [NStg];
  logic [QUOT_W-1:0] quot_q   [NStg];
  logic [TotW-1:0]   dvs_q    [NStg];
  logic              neg_q    [NStg];
  logic              zero_q   [NStg];
  lpc_status_t       status_q [NStg];

  logic                    ov_q;
  lpc_status_t             ostatus_q;
  logic signed [POS_W-1:0] opos_q;
  logic                    opos_valid_q;
  logic [POS_W-1:0]        qext;

  assign rdy[NStg] = !ov_q || ready_i;
  assign ready_o   = rdy[0];

  for (genvar s = 0; s < NStg; s++) begin : g_stage
    localparam int unsigned K = NStg - 1 - s;

    logic              vin;
    logic [MagW-1:0]   rin;
    logic [QUOT_W-1:0] qin;
    logic [TotW-1:0]   din;
    logic              nin, zin;
    lpc_status_t       sin;
    logic [MagW:0]     dsh;
    logic [MagW:0]     diff;
    logic              take;
    logic [MagW-1:0]   rem_d;
    logic [QUOT_W-1:0] quot_d;

    if (s == 0) begin : g_first
      assign vin = valid_i;
      assign rin = mag_i;
      assign qin = '0;
      assign din = total_i;
      assign nin = neg_i;
      assign zin = zero_i;
      assign sin = status_i;
    end else begin : g_next
      assign vin = v_q[s-1];
      assign rin = rem_q[s-1];
      assign qin = quot_q[s-1];
      assign din = dvs_q[s-1];
      assign nin = neg_q[s-1];
      assign zin = zero_q[s-1];
      assign sin = status_q[s-1];
    end

    assign rdy[s] = !v_q[s] || rdy[s+1];

    always_comb begin
      dsh       = (MagW + 1)'(din) << K;
      diff      = {1'b0, rin} - dsh;
      take      = !diff[MagW];
      rem_d     = take ? diff[MagW-1:0] : rin;
      quot_d    = qin;
      quot_d[K] = take;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && vin) begin
        rem_q[s]    <= rem_d;
        quot_q[s]   <= quot_d;
        dvs_q[s]    <= din;
        neg_q[s]    <= nin;
        zero_q[s]   <= zin;
        status_q[s] <= sin;
      end
    end
  end

  assign qext = POS_W'(quot_q[NStg-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (rdy[NStg]) begin
      ov_q <= v_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NStg] && v_q[NStg-1]) begin
      ostatus_q    <= status_q[NStg-1];
      opos_valid_q <= !zero_q[NStg-1];
      // A zero total strength reports position 0.
      if (zero_q[NStg-1]) begin
        opos_q <= '0;
      end else if (neg_q[NStg-1]) begin
        opos_q <= -$signed(qext);
      end else begin
        opos_q <= $signed(qext);
      end
    end
  end

  assign valid_o          = ov_q;
  assign status_o         = ostatus_q;
  assign position_o       = opos_q;
  assign position_valid_o = opos_valid_q;

endmodule

[hdl/line_position_centroid_unit.sv]
// Line position centroid unit: six lanes, a merging stage and a divider pipeline.
// Pipeline: 1 lane stage, 2 merge stages, 12 divider stages and 1 output register
// lie between request acceptance and result valid.
// Throughput: one request per cycle; every stage has its own valid and stalls
// only when full and blocked downstream. Reset empties the pipeline and loads
// threshold 2000 and line_reads_low 1. Depends on lpc_pkg, lpc_in_if, lpc_out_if.
module line_position_centroid_unit #(
  parameter int unsigned AdcFullScale = lpc_pkg::ADC_FULL_SCALE_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lpc_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [lpc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  lpc_in_if.sink                           req_i,
  lpc_out_if.source                        rsp_o
);
  import lpc_pkg::*;

  localparam int unsigned StrW  = str_width(AdcFullScale);
  localparam int unsigned ProdW = StrW + WEIGHT_W;
  localparam int unsigned TotW  = StrW + 3;
  localparam int unsigned MagW  = TotW + QUOT_W;

  logic [SAMPLE_W-1:0] thr_q;
  logic                reads_low_q;

  logic                lane_v_q;
  logic                lane_rdy;
  logic                lane_en;
  logic                merge_rdy;
  logic [SAMPLE_W-1:0] samples [NUM_LANES];
  logic                on_line  [NUM_LANES];
  logic [StrW-1:0]     strength [NUM_LANES];
  logic [ProdW-1:0]    prod     [NUM_LANES];

  logic                m_valid, div_rdy;
  lpc_status_t         m_status, o_status;
  logic                m_neg, m_zero;
  logic [MagW-1:0]     m_mag;
  logic [TotW-1:0]     m_total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THRESH_RESET;
      reads_low_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_LINE_THRESHOLD: thr_q       <= cfg_data_i[SAMPLE_W-1:0];
        CFG_LINE_READS_LOW: reads_low_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign samples[0] = req_i.sample_0;
  assign samples[1] = req_i.sample_1;
  assign samples[2] = req_i.sample_2;
  assign samples[3] = req_i.sample_3;
  assign samples[4] = req_i.sample_4;
  assign samples[5] = req_i.sample_5;

  assign lane_rdy    = !lane_v_q || merge_rdy;
  assign lane_en     = req_i.valid && lane_rdy;
  assign req_i.ready = lane_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_v_q <= 1'b0;
    end else if (lane_rdy) begin
      lane_v_q <= req_i.valid;
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    lpc_lane #(
      .AdcFullScale (AdcFullScale),
      .WeightMag    (WEIGHT_MAG[i])
    ) u_lane (
      .clk_i       (clk_i),
      .en_i        (lane_en),
      .sample_i    (samples[i]),
      .threshold_i (thr_q),
      .reads_low_i (reads_low_q),
      .on_line_o   (on_line[i]),
      .strength_o  (strength[i]),
      .prod_o      (prod[i])
    );
  end

  lpc_merge #(
    .AdcFullScale (AdcFullScale)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (lane_v_q),
    .ready_o    (merge_rdy),
    .on_line_i  (on_line),
    .strength_i (strength),
    .prod_i     (prod),
    .valid_o    (m_valid),
    .ready_i    (div_rdy),
    .status_o   (m_status),
    .neg_o      (m_neg),
    .zero_o     (m_zero),
    .mag_o      (m_mag),
    .total_o    (m_total)
  );

  lpc_div #(
    .AdcFullScale (AdcFullScale)
  ) u_div (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (m_valid),
    .ready_o          (div_rdy),
    .status_i         (m_status),
    .neg_i            (m_neg),
    .zero_i           (m_zero),
    .mag_i            (m_mag),
    .total_i          (m_total),
    .valid_o          (rsp_o.valid),
    .ready_i          (rsp_o.ready),
    .status_o         (o_status),
    .position_o       (rsp_o.position),
    .position_valid_o (rsp_o.position_valid)
  );

  assign rsp_o.sensor_mask = o_status.mask;
  assign rsp_o.sensor_hits = o_status.count;

endmodule
